// File: hdl/radial_line_rasterizer_defines.svh
// Assertion macros for the radial line rasterizer.
`ifndef RADIAL_LINE_RASTERIZER_DEFINES_SVH
`define RADIAL_LINE_RASTERIZER_DEFINES_SVH
`ifndef SYNTHESIS
`define RLR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("radial_line_rasterizer: same-cycle assertion failed");
`define RLR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("radial_line_rasterizer: next-cycle assertion failed");
`else
`define RLR_ASSERT_IMPL(label, ante, cons)
`define RLR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hdl/rlr_pkg.sv
// Shared constants and types of the radial line rasterizer.
package rlr_pkg;

  localparam int MAX_LENGTH = 64;
  localparam int MAX_COORD  = 4096;

  localparam int COORD_W   = 12;
  localparam int DIM_W     = 13;
  localparam int LEN_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int ACC_W     = 38;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 2'd3;

  localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = 13'd3840;
  localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = 13'd2160;
  localparam logic [COORD_W-1:0] RST_CENTER_X     = 12'd1920;
  localparam logic [COORD_W-1:0] RST_CENTER_Y     = 12'd1080;

  typedef struct packed {
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
  } rlr_cfg_t;

  typedef struct packed {
    logic load;
    logic setup1;
    logic setup2;
    logic setup3;
    logic step;
    logic load_pend;
    logic push;
    logic last;
  } rlr_cmd_t;

  typedef struct packed {
    logic on_center;
    logic cand_ok;
    logic out_free;
  } rlr_sts_t;

endpackage

// File: hdl/rlr_in_if.sv
// Input channel carrying one line request word.
interface rlr_in_if;
  logic                         valid;
  logic                         ready;
  logic [rlr_pkg::COORD_W-1:0]  start_x;
  logic [rlr_pkg::COORD_W-1:0]  start_y;
  logic [rlr_pkg::LEN_W-1:0]    line_length;

  modport source(output valid, output start_x, output start_y, output line_length,
                 input ready);
  modport sink(input valid, input start_x, input start_y, input line_length,
               output ready);
endinterface

// File: hdl/rlr_out_if.sv
// Output channel carrying one pixel word.
interface rlr_out_if;
  logic                         valid;
  logic                         ready;
  logic [rlr_pkg::COORD_W-1:0]  pixel_x;
  logic [rlr_pkg::COORD_W-1:0]  pixel_y;
  logic                         last_pixel;

  modport source(output valid, output pixel_x, output pixel_y, output last_pixel,
                 input ready);
  modport sink(input valid, input pixel_x, input pixel_y, input last_pixel,
               output ready);
endinterface

// File: hdl/rlr_cfg_regs.sv
// Configuration register bank of the radial line rasterizer.
module rlr_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rlr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rlr_pkg::DIM_W-1:0]         cfg_data,
  output rlr_pkg::rlr_cfg_t                 cfg
);
  import rlr_pkg::*;

  rlr_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= RST_FRAME_WIDTH;
      cfg_r.frame_height <= RST_FRAME_HEIGHT;
      cfg_r.center_x     <= RST_CENTER_X;
      cfg_r.center_y     <= RST_CENTER_Y;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_data;
        CFG_CENTER_X:     cfg_r.center_x     <= cfg_data[COORD_W-1:0];
        CFG_CENTER_Y:     cfg_r.center_y     <= cfg_data[COORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hdl/rlr_ctrl.sv
// Controller state machine sequencing setup and pixel stepping.
module rlr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rlr_pkg::rlr_sts_t sts,
  output rlr_pkg::rlr_cmd_t cmd
);
  import rlr_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SETUP1 = 3'd1;
  localparam logic [2:0] ST_SETUP2 = 3'd2;
  localparam logic [2:0] ST_SETUP3 = 3'd3;
  localparam logic [2:0] ST_RUN    = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       has_pend_r, has_pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      has_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      has_pend_r <= has_pend_nxt;
    end
  end

  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    has_pend_nxt = has_pend_r;
    in_ready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        has_pend_nxt = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP1;
        end
      end
      ST_SETUP1: begin
        if (sts.on_center) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.setup1 = 1'b1;
          state_nxt  = ST_SETUP2;
        end
      end
      ST_SETUP2: begin
        cmd.setup2 = 1'b1;
        state_nxt  = ST_SETUP3;
      end
      ST_SETUP3: begin
        cmd.setup3   = 1'b1;
        has_pend_nxt = 1'b0;
        state_nxt    = ST_RUN;
      end
      ST_RUN: begin
        if (sts.out_free) begin
          cmd.push = has_pend_r;
          if (sts.cand_ok) begin
            cmd.step      = 1'b1;
            cmd.load_pend = 1'b1;
            has_pend_nxt  = 1'b1;
          end else begin
            cmd.last     = 1'b1;
            has_pend_nxt = 1'b0;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/rlr_datapath.sv
// Datapath: setup arithmetic, incremental step tests and the output register.
module rlr_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rlr_pkg::rlr_cmd_t             cmd,
  input  rlr_pkg::rlr_cfg_t             cfg,
  input  logic [rlr_pkg::COORD_W-1:0]   start_x,
  input  logic [rlr_pkg::COORD_W-1:0]   start_y,
  input  logic [rlr_pkg::LEN_W-1:0]     line_length,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [rlr_pkg::COORD_W-1:0]   pixel_x,
  output logic [rlr_pkg::COORD_W-1:0]   pixel_y,
  output logic                          last_pixel,
  output rlr_pkg::rlr_sts_t             sts
);
  import rlr_pkg::*;

  logic [COORD_W-1:0]      sx_r, sy_r;
  logic [LEN_W-1:0]        len_r;
  logic signed [DIM_W-1:0] dx_r, dy_r;
  logic                    on_center_r;

  logic                    xmaj_r, neg_r;
  logic [COORD_W-1:0]      amaj_r;
  logic signed [DIM_W-1:0] minor_r;
  logic [18:0]             al_r;
  logic [23:0]             sqx_r, sqy_r;
  logic [ACC_W-1:0]        limit_r;
  logic [24:0]             dist2_r;
  logic [ACC_W-1:0]        acc_r, inc_r;
  logic [LEN_W-1:0]        i_r;
  logic signed [7:0]       q_r;
  logic [DIM_W-1:0]        r_r;

  logic [COORD_W-1:0]      pend_x_r, pend_y_r;
  logic                    out_valid_r;
  logic [COORD_W-1:0]      out_x_r, out_y_r;
  logic                    out_last_r;

  logic [COORD_W-1:0]      adx, ady, amaj_c;
  logic                    xmaj_c;
  logic [DIM_W-1:0]        d_w;
  logic signed [15:0]      r_sum, d_ext;
  logic signed [7:0]       moff, majd;
  logic signed [14:0]      px_c, py_c, fw_c, fh_c;
  logic [DIM_W-1:0]        fw_lim, fh_lim;
  logic                    in_frame;

  assign adx    = dx_r[DIM_W-1] ? COORD_W'(-dx_r) : COORD_W'(dx_r);
  assign ady    = dy_r[DIM_W-1] ? COORD_W'(-dy_r) : COORD_W'(dy_r);
  assign xmaj_c = adx > ady;
  assign amaj_c = xmaj_c ? adx : ady;

  assign d_w   = {amaj_r, 1'b0};
  assign d_ext = $signed({3'b000, d_w});
  assign r_sum = $signed({3'b000, r_r}) + $signed({{2{minor_r[DIM_W-1]}}, minor_r, 1'b0});

  assign moff = (q_r < 0 && r_r != '0) ? q_r + 8'sd1 : q_r;
  assign majd = neg_r ? -$signed({1'b0, i_r}) : $signed({1'b0, i_r});

  assign px_c = $signed({3'b000, sx_r}) + (xmaj_r ? 15'(majd) : 15'(moff));
  assign py_c = $signed({3'b000, sy_r}) + (xmaj_r ? 15'(moff) : 15'(majd));

  assign fw_lim = (cfg.frame_width > DIM_W'(MAX_COORD)) ? DIM_W'(MAX_COORD) : cfg.frame_width;
  assign fh_lim = (cfg.frame_height > DIM_W'(MAX_COORD)) ? DIM_W'(MAX_COORD)
                                                          : cfg.frame_height;
  assign fw_c   = $signed({2'b00, fw_lim});
  assign fh_c   = $signed({2'b00, fh_lim});

  assign in_frame = !px_c[14] && (px_c < fw_c) && !py_c[14] && (py_c < fh_c);

  assign sts.cand_ok   = (i_r < LEN_W'(MAX_LENGTH)) && (acc_r < limit_r) && in_frame;
  assign sts.on_center = on_center_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx_r        <= start_x;
      sy_r        <= start_y;
      len_r       <= (line_length > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : line_length;
      dx_r        <= $signed({1'b0, start_x}) - $signed({1'b0, cfg.center_x});
      dy_r        <= $signed({1'b0, start_y}) - $signed({1'b0, cfg.center_y});
      on_center_r <= (start_x == cfg.center_x) && (start_y == cfg.center_y);
    end
    if (cmd.setup1) begin
      xmaj_r  <= xmaj_c;
      neg_r   <= xmaj_c ? dx_r[DIM_W-1] : dy_r[DIM_W-1];
      minor_r <= xmaj_c ? dy_r : dx_r;
      amaj_r  <= amaj_c;
      al_r    <= 19'(amaj_c) * 19'(len_r);
      sqx_r   <= 24'(adx) * 24'(adx);
    end
    if (cmd.setup2) begin
      limit_r <= ACC_W'(al_r) * ACC_W'(al_r);
      sqy_r   <= 24'(ady) * 24'(ady);
    end
    if (cmd.setup3) begin
      dist2_r <= 25'(sqx_r) + 25'(sqy_r);
      inc_r   <= ACC_W'(sqx_r) + ACC_W'(sqy_r);
      acc_r   <= '0;
      i_r     <= '0;
      q_r     <= '0;
      r_r     <= {1'b0, amaj_r};
    end else if (cmd.step) begin
      acc_r <= acc_r + inc_r;
      inc_r <= inc_r + ACC_W'({dist2_r, 1'b0});
      i_r   <= i_r + 1'b1;
      if (r_sum >= d_ext) begin
        r_r <= DIM_W'(r_sum - d_ext);
        q_r <= q_r + 8'sd1;
      end else if (r_sum < 0) begin
        r_r <= DIM_W'(r_sum + d_ext);
        q_r <= q_r - 8'sd1;
      end else begin
        r_r <= DIM_W'(r_sum);
      end
    end
    if (cmd.load_pend) begin
      pend_x_r <= px_c[COORD_W-1:0];
      pend_y_r <= py_c[COORD_W-1:0];
    end
    if (cmd.push) begin
      out_x_r    <= pend_x_r;
      out_y_r    <= pend_y_r;
      out_last_r <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign pixel_x    = out_x_r;
  assign pixel_y    = out_y_r;
  assign last_pixel = out_last_r;

endmodule

// File: hdl/radial_line_rasterizer.sv
// Radial line rasterizer: one accepted word (start pixel and length) produces the pixels of
// a short line running straight away from the configured center, stepped along the dominant
// axis, with last_pixel set on the final pixel; a start on the center, a zero length or a
// start outside the frame produces no pixel. Lines are handled one at a time: after the
// accept the setup states SETUP1, SETUP2 and SETUP3 form the squared-length limit and the
// minor-axis ratio, then the stepping loop, the single incremental step unit, delivers one
// pixel per cycle while the output is not stalled, and a final step closes the run.
// Configuration writes are taken at any time but belong between lines.
`include "radial_line_rasterizer_defines.svh"
module radial_line_rasterizer (
  input  logic                            clk,
  input  logic                            rst_n,
  rlr_in_if.sink                          in_chan,
  rlr_out_if.source                       out_chan,
  input  logic                            cfg_we,
  input  logic [rlr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rlr_pkg::DIM_W-1:0]       cfg_data
);
  import rlr_pkg::*;

  rlr_cfg_t cfg;
  rlr_cmd_t cmd;
  rlr_sts_t sts;

  rlr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rlr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rlr_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg         (cfg),
    .start_x     (in_chan.start_x),
    .start_y     (in_chan.start_y),
    .line_length (in_chan.line_length),
    .out_ready   (out_chan.ready),
    .out_valid   (out_chan.valid),
    .pixel_x     (out_chan.pixel_x),
    .pixel_y     (out_chan.pixel_y),
    .last_pixel  (out_chan.last_pixel),
    .sts         (sts)
  );

  `RLR_ASSERT_IMPL(a_push_into_free_slot, cmd.push, sts.out_free)
  `RLR_ASSERT_NEXT(a_one_line_at_a_time, in_chan.valid && in_chan.ready, !in_chan.ready)
  `RLR_ASSERT_IMPL(a_step_only_when_valid, cmd.step, sts.cand_ok && cmd.load_pend)

endmodule
